// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, reset by i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// same, with a custom message
`define ASSERT_CLK_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_CLK_MSG(lbl, prop, msg)

`endif

`endif

// ----- hdl/gha_pkg.sv -----
// ---------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the generational handle allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

    localparam int IDX_FIELD_W  = 10;
    localparam int GEN_FIELD_W  = 32;
    localparam int MASK_FIELD_W = 32;

    // request codes
    localparam logic [1:0] ACT_CREATE   = 2'd0;
    localparam logic [1:0] ACT_DESTROY  = 2'd1;
    localparam logic [1:0] ACT_SET_MASK = 2'd2;
    localparam logic [1:0] ACT_QUERY    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_FIELD_W-1:0]  slot_index;
        logic [GEN_FIELD_W-1:0]  handle_generation;
        logic [MASK_FIELD_W-1:0] new_mask;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [IDX_FIELD_W-1:0]  out_index;
        logic [GEN_FIELD_W-1:0]  out_generation;
        logic [MASK_FIELD_W-1:0] out_mask;
        logic                    is_valid;
        logic                    is_alive;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_QREAD,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // init sweep writes one entry
        logic load;     // request transfer, issue slot reads
        logic slot_rd;  // create: read generation of dequeued slot
        logic exec;     // commit writes and load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic need_qread;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/generational_handle_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// generational_handle_allocator_unit
// Fixed pool of slots handed out as (index, generation) handles.
//
//   channel  | valid   | ready   | payload
//   ---------+---------+---------+----------------------
//   request  | i_valid | o_ready | i_req (gha_pkg::t_req)
//   result   | o_valid | i_ready | o_rsp (gha_pkg::t_rsp)
//
// One request in flight. Destroy, set mask, query and a create on a full
// pool take a slot memory read, then write-back; any other create takes a
// free queue read, then the slot's generation read at the dequeued index,
// then write-back.
// After reset an init sweep writes all slot memories and the free queue,
// one entry per cycle, with o_ready low.
// A held result stalls the write-back of the next request only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module generational_handle_allocator_unit #(
    parameter int SLOT_COUNT = 1024,
    parameter int MASK_BITS  = 32,
    parameter int GEN_BITS   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gha_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output gha_pkg::t_rsp o_rsp
);

    gha_pkg::t_cmd  cmd;
    gha_pkg::t_stat stat;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gha_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .MASK_BITS  (MASK_BITS),
        .GEN_BITS   (GEN_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // write-back never overruns a result that is still held
    `ASSERT_CLK(a_exec_room, cmd.exec |-> (!o_valid || i_ready))
    // one request at a time: no transfer right after a transfer
    `ASSERT_CLK(a_single_flight, (i_valid && o_ready) |=> !o_ready)
    // a create with free slots goes through the queue read step
    `ASSERT_CLK_MSG(a_create_qread, (i_valid && o_ready && stat.need_qread) |=> cmd.slot_rd,
        "create skipped queue read")
    // a write-back always presents a result next cycle
    `ASSERT_CLK(a_exec_result, cmd.exec |=> o_valid)

endmodule

// ----- hdl/gha_ctrl.sv -----
// ---------------------------------------------------------------------------
// gha_ctrl
// Sequencer: init sweep after reset, then one request at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  gha_pkg::t_stat i_stat,
    output gha_pkg::t_cmd  o_cmd
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            gha_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = gha_pkg::S_IDLE;
                end
            end
            gha_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_stat.need_qread ? gha_pkg::S_QREAD : gha_pkg::S_EXEC;
                end
            end
            gha_pkg::S_QREAD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = gha_pkg::S_EXEC;
            end
            gha_pkg::S_EXEC: begin
                // hold until the result register can take the new result
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = gha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/gha_dpath.sv -----
// ---------------------------------------------------------------------------
// gha_dpath
// Slot memories, free queue, request and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_dpath #(
    parameter int SLOT_COUNT = 1024,
    parameter int MASK_BITS  = 32,
    parameter int GEN_BITS   = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gha_pkg::t_req  i_req,
    input  gha_pkg::t_cmd  i_cmd,
    output gha_pkg::t_stat o_stat,
    input  logic           i_ready,
    output logic           o_valid,
    output gha_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int FW    = gha_pkg::IDX_FIELD_W;
    localparam int GW    = gha_pkg::GEN_FIELD_W;
    localparam int MW    = gha_pkg::MASK_FIELD_W;

    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W+FW-1:0] POOL_END   = (IDX_W + FW)'(SLOT_COUNT);

    logic [MASK_BITS-1:0] mem_mask  [SLOT_COUNT];
    logic [GEN_BITS-1:0]  mem_gen   [SLOT_COUNT];
    logic                 mem_alloc [SLOT_COUNT];
    logic [IDX_W-1:0]     mem_queue [SLOT_COUNT];

    gha_pkg::t_req        r_req;
    logic                 r_oor;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [MASK_BITS-1:0] r_mask_rd;
    logic [GEN_BITS-1:0]  r_gen_rd;
    logic                 r_alloc_rd;
    logic [IDX_W-1:0]     r_q_rd;
    logic                 r_out_valid;
    gha_pkg::t_rsp        r_out;
    gha_pkg::t_rsp        n_out;

    // index / width adaptation
    logic [IDX_W+FW-1:0]   in_idx_wide;
    logic [IDX_W+FW-1:0]   req_idx_wide;
    logic [IDX_W+FW-1:0]   slot_wide;
    logic [IDX_W-1:0]      in_addr;
    logic [IDX_W-1:0]      req_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic [MASK_BITS+MW-1:0] nmask_wide;
    logic [MASK_BITS-1:0]  nmask;
    logic [MASK_BITS+MW-1:0] nmask_ext;
    logic [MASK_BITS+MW-1:0] mask_rd_wide;
    logic [GEN_BITS+GW-1:0] gen_rd_wide;
    logic [GEN_BITS-1:0]   gen_up;
    logic [GEN_BITS+GW-1:0] gen_up_wide;
    logic [GW-1:0]         gen_rd32;
    logic [GW-1:0]         gen_up32;
    logic                  hit;

    // write side
    logic                  we_mask;
    logic                  we_gen;
    logic                  we_alloc;
    logic                  we_queue;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      q_waddr;
    logic [MASK_BITS-1:0]  mask_wd;
    logic [GEN_BITS-1:0]   gen_wd;
    logic                  alloc_wd;
    logic [IDX_W-1:0]      q_wd;
    logic                  head_inc;
    logic                  tail_inc;
    logic                  cnt_dec;
    logic                  cnt_inc;

    assign in_idx_wide  = {{IDX_W{1'b0}}, i_req.slot_index};
    assign req_idx_wide = {{IDX_W{1'b0}}, r_req.slot_index};
    assign slot_wide    = {{FW{1'b0}}, r_q_rd};
    assign in_addr      = in_idx_wide[IDX_W-1:0];
    assign req_addr     = req_idx_wide[IDX_W-1:0];
    assign rd_addr      = i_cmd.slot_rd ? r_q_rd : in_addr;

    assign nmask_wide   = {{MASK_BITS{1'b0}}, r_req.new_mask};
    assign nmask        = nmask_wide[MASK_BITS-1:0];
    // stored mask as reported: only MASK_BITS of it survive
    assign nmask_ext    = {{MW{1'b0}}, nmask};
    assign mask_rd_wide = {{MW{1'b0}}, r_mask_rd};
    assign gen_rd_wide  = {{GW{1'b0}}, r_gen_rd};
    assign gen_up       = r_gen_rd + GEN_BITS'(1);
    assign gen_up_wide  = {{GW{1'b0}}, gen_up};
    assign gen_rd32     = gen_rd_wide[GW-1:0];
    assign gen_up32     = gen_up_wide[GW-1:0];
    assign hit          = (gen_rd32 == r_req.handle_generation);

    assign o_stat.clr_last   = (r_clr_idx == LAST_IDX);
    assign o_stat.need_qread = (i_req.action == gha_pkg::ACT_CREATE) && (r_count != '0);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // ---------------- request capture and result register ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_oor <= (in_idx_wide >= POOL_END);
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // ---------------- queue pointers and init sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= FULL_COUNT;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clr && !o_stat.clr_last) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (head_inc) begin
                r_head <= (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
            end
            if (tail_inc) begin
                r_tail <= (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
            end
            if (cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end else if (cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (we_mask) begin
            mem_mask[wr_addr] <= mask_wd;
        end
        if (i_cmd.load) begin
            r_mask_rd <= mem_mask[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_gen) begin
            mem_gen[wr_addr] <= gen_wd;
        end
        if (i_cmd.load || i_cmd.slot_rd) begin
            r_gen_rd <= mem_gen[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_alloc) begin
            mem_alloc[wr_addr] <= alloc_wd;
        end
        if (i_cmd.load) begin
            r_alloc_rd <= mem_alloc[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_queue) begin
            mem_queue[q_waddr] <= q_wd;
        end
        if (i_cmd.load) begin
            r_q_rd <= mem_queue[r_head];
        end
    end

    // ---------------- request execution ----------------
    always_comb begin
        n_out    = '0;
        we_mask  = 1'b0;
        we_gen   = 1'b0;
        we_alloc = 1'b0;
        we_queue = 1'b0;
        wr_addr  = req_addr;
        q_waddr  = r_tail;
        mask_wd  = nmask;
        gen_wd   = gen_up;
        alloc_wd = 1'b0;
        q_wd     = req_addr;
        head_inc = 1'b0;
        tail_inc = 1'b0;
        cnt_dec  = 1'b0;
        cnt_inc  = 1'b0;

        // default report: current slot contents against the handle, for an in-range index
        n_out.status    = gha_pkg::ST_OK;
        n_out.out_index = r_req.slot_index;
        if (!r_oor) begin
            n_out.out_generation = gen_rd32;
            n_out.out_mask       = mask_rd_wide[MW-1:0];
            n_out.is_valid       = hit;
            n_out.is_alive       = hit && r_mask_rd[0];
        end

        case (r_req.action)
            gha_pkg::ACT_CREATE: begin
                if (r_count == '0) begin
                    n_out        = '0;
                    n_out.status = gha_pkg::ST_FULL;
                end else begin
                    wr_addr  = r_q_rd;
                    we_mask  = i_cmd.exec;
                    we_alloc = i_cmd.exec;
                    alloc_wd = 1'b1;
                    head_inc = i_cmd.exec;
                    cnt_dec  = i_cmd.exec;
                    n_out.out_index      = slot_wide[FW-1:0];
                    n_out.out_generation = gen_rd32;
                    n_out.out_mask       = nmask_ext[MW-1:0];
                    n_out.is_valid       = 1'b1;
                    n_out.is_alive       = nmask[0];
                end
            end
            gha_pkg::ACT_DESTROY: begin
                if (r_oor || !r_alloc_rd) begin
                    n_out.status = gha_pkg::ST_UNALLOC;
                end else begin
                    mask_wd  = '0;
                    we_mask  = i_cmd.exec;
                    we_gen   = i_cmd.exec;
                    we_alloc = i_cmd.exec;
                    if (r_count < FULL_COUNT) begin
                        we_queue = i_cmd.exec;
                        tail_inc = i_cmd.exec;
                        cnt_inc  = i_cmd.exec;
                    end
                    n_out.out_generation = gen_up32;
                    n_out.out_mask       = '0;
                    n_out.is_valid       = (gen_up32 == r_req.handle_generation);
                    n_out.is_alive       = 1'b0;
                end
            end
            gha_pkg::ACT_SET_MASK: begin
                if (!r_oor) begin
                    we_mask = i_cmd.exec;
                    n_out.out_mask = nmask_ext[MW-1:0];
                    n_out.is_alive = hit && nmask[0];
                end
            end
            default: begin
            end
        endcase

        // init sweep: every slot free, generation one, queue in index order
        if (i_cmd.clr) begin
            wr_addr  = r_clr_idx;
            q_waddr  = r_clr_idx;
            mask_wd  = '0;
            gen_wd   = GEN_BITS'(1);
            alloc_wd = 1'b0;
            q_wd     = r_clr_idx;
            we_mask  = 1'b1;
            we_gen   = 1'b1;
            we_alloc = 1'b1;
            we_queue = 1'b1;
        end
    end

endmodule

// ----- sim/tb_generational_handle_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_generational_handle_allocator_unit
// Self-checking bench for the generational handle allocator. A slot pool
// model predicts every response from the accepted requests; responses are
// compared field by field in order. Directed handle life cycles come first,
// then random traffic, a fill of the pool up to full, and a drain-heavy tail,
// with random idle bursts on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_allocator_unit;

    localparam int SLOTS       = 1 << gha_pkg::IDX_FIELD_W;
    localparam int LIMIT_NS    = 8 * 400000;
    localparam int TAIL_CYCLES = 8;

    // Slot pool model and in-order response check.
    class slot_pool_model;
        logic [gha_pkg::MASK_FIELD_W-1:0] slot_mask [SLOTS];
        logic [gha_pkg::GEN_FIELD_W-1:0]  slot_gen  [SLOTS];
        bit                               slot_used [SLOTS];
        logic [gha_pkg::IDX_FIELD_W-1:0]  free_ring [SLOTS];
        logic [gha_pkg::IDX_FIELD_W-1:0]  ring_rd;
        logic [gha_pkg::IDX_FIELD_W-1:0]  ring_wr;
        int                               free_count;
        gha_pkg::t_rsp                    due_rsps [$];
        int                               requests;
        int                               checked;
        int                               full_hits;
        int                               mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_mask[i] = '0;
                slot_gen[i]  = 1;
                slot_used[i] = 1'b0;
                free_ring[i] = i[gha_pkg::IDX_FIELD_W-1:0];
            end
            ring_rd    = '0;
            ring_wr    = '0;
            free_count = SLOTS;
            requests   = 0;
            checked    = 0;
            full_hits  = 0;
            mismatches = 0;
        endfunction

        function gha_pkg::t_rsp slot_view(logic [1:0] st,
                                          logic [gha_pkg::IDX_FIELD_W-1:0] s,
                                          logic [gha_pkg::GEN_FIELD_W-1:0] hg);
            gha_pkg::t_rsp v;
            v.status         = st;
            v.out_index      = s;
            v.out_generation = slot_gen[s];
            v.out_mask       = slot_mask[s];
            v.is_valid       = (slot_gen[s] == hg);
            v.is_alive       = v.is_valid & slot_mask[s][0];
            return v;
        endfunction

        // called once per accepted request transfer
        function gha_pkg::t_rsp apply_request(gha_pkg::t_req r);
            gha_pkg::t_rsp                   e;
            logic [gha_pkg::IDX_FIELD_W-1:0] s;
            e = '0;
            s = r.slot_index;
            requests++;
            case (r.action)
                gha_pkg::ACT_CREATE: begin
                    if (free_count == 0) begin
                        e.status = gha_pkg::ST_FULL;
                        full_hits++;
                    end else begin
                        s = free_ring[ring_rd];
                        ring_rd++;
                        free_count--;
                        slot_mask[s]     = r.new_mask;
                        slot_used[s]     = 1'b1;
                        e.status         = gha_pkg::ST_OK;
                        e.out_index      = s;
                        e.out_generation = slot_gen[s];
                        e.out_mask       = r.new_mask;
                        e.is_valid       = 1'b1;
                        e.is_alive       = r.new_mask[0];
                    end
                end
                gha_pkg::ACT_DESTROY: begin
                    if (!slot_used[s]) begin
                        e = slot_view(gha_pkg::ST_UNALLOC, s, r.handle_generation);
                    end else begin
                        // generation is not checked on destroy
                        slot_mask[s] = '0;
                        slot_gen[s]++;
                        slot_used[s] = 1'b0;
                        if (free_count < SLOTS) begin
                            free_ring[ring_wr] = s;
                            ring_wr++;
                            free_count++;
                        end
                        e = slot_view(gha_pkg::ST_OK, s, r.handle_generation);
                    end
                end
                gha_pkg::ACT_SET_MASK: begin
                    slot_mask[s] = r.new_mask;
                    e = slot_view(gha_pkg::ST_OK, s, r.handle_generation);
                end
                default: e = slot_view(gha_pkg::ST_OK, s, r.handle_generation);
            endcase
            due_rsps = {due_rsps, e};
            return e;
        endfunction

        task flag(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        endtask

        task check_response(gha_pkg::t_rsp got);
            gha_pkg::t_rsp want;
            checked++;
            if (due_rsps.size() == 0) begin
                flag("response with nothing outstanding", 64'(got.out_index), 64'(0));
                return;
            end
            want = due_rsps.pop_front();
            if (got.status !== want.status)
                flag("status", 64'(got.status), 64'(want.status));
            if (got.out_index !== want.out_index)
                flag("out_index", 64'(got.out_index), 64'(want.out_index));
            if (got.out_generation !== want.out_generation)
                flag("out_generation", 64'(got.out_generation), 64'(want.out_generation));
            if (got.out_mask !== want.out_mask)
                flag("out_mask", 64'(got.out_mask), 64'(want.out_mask));
            if (got.is_valid !== want.is_valid)
                flag("is_valid", 64'(got.is_valid), 64'(want.is_valid));
            if (got.is_alive !== want.is_alive)
                flag("is_alive", 64'(got.is_alive), 64'(want.is_alive));
        endtask
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    gha_pkg::t_req req;
    logic          rsp_valid;
    logic          rsp_ready;
    gha_pkg::t_rsp rsp;

    slot_pool_model pool;
    int             live [$];   // slots the model holds as allocated
    bit             calm;       // no idling on either side

    generational_handle_allocator_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_req   (req),
        .o_valid (rsp_valid),
        .i_ready (rsp_ready),
        .o_rsp   (rsp)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready)
            pool.check_response(rsp);
    end

    // result side back-pressure
    initial begin
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(60, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout, %0d responses still outstanding", pool.due_rsps.size());
        $display("tb_generational_handle_allocator_unit NOT OK");
        $finish;
    end

    function automatic gha_pkg::t_req build_req(logic [1:0] a, int unsigned s,
                                                logic [31:0] g, logic [31:0] m);
        gha_pkg::t_req r;
        r.action            = a;
        r.slot_index        = s[gha_pkg::IDX_FIELD_W-1:0];
        r.handle_generation = g;
        r.new_mask          = m;
        return r;
    endfunction

    // weights in percent for create, destroy, set mask; the rest is query
    function automatic gha_pkg::t_req random_req(int cw, int dw, int sw);
        gha_pkg::t_req r;
        int            pick;
        int            s;
        pick = $urandom_range(0, 99);
        s    = $urandom_range(0, SLOTS - 1);
        r.slot_index        = s[gha_pkg::IDX_FIELD_W-1:0];
        r.handle_generation = $urandom;
        r.new_mask          = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom;
        if (pick < cw) begin
            r.action = gha_pkg::ACT_CREATE;
            return r;
        end
        if (pick < cw + dw)
            r.action = gha_pkg::ACT_DESTROY;
        else if (pick < cw + dw + sw)
            r.action = gha_pkg::ACT_SET_MASK;
        else
            r.action = gha_pkg::ACT_QUERY;
        if (live.size() > 0 && $urandom_range(0, 9) < 7) begin
            s = live[$urandom_range(0, live.size() - 1)];
            r.slot_index = s[gha_pkg::IDX_FIELD_W-1:0];
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r.handle_generation = pool.slot_gen[s];
            6, 7:             r.handle_generation = pool.slot_gen[s] - 1;  // stale handle
            default: ;
        endcase
        return r;
    endfunction

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic push_req(gha_pkg::t_req r);
        gha_pkg::t_rsp want;
        sender_gap();
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        want = pool.apply_request(r);
        if (want.status == gha_pkg::ST_OK && r.action == gha_pkg::ACT_CREATE) begin
            live = {live, int'(want.out_index)};
        end else if (want.status == gha_pkg::ST_OK && r.action == gha_pkg::ACT_DESTROY) begin
            foreach (live[k]) begin
                if (live[k] == want.out_index) begin
                    live.delete(k);
                    break;
                end
            end
        end
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pool.due_rsps.size() > 0) @(posedge clk);
    endtask

    initial begin
        pool      = new();
        calm      = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset view, unallocated ops, FIFO order, stale destroy
        push_req(build_req(gha_pkg::ACT_QUERY,    0,    32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_QUERY,    1023, 32'hFFFFFFFF, 32'hFFFFFFFF));
        push_req(build_req(gha_pkg::ACT_QUERY,    512,  32'd0,        32'd0));
        push_req(build_req(gha_pkg::ACT_DESTROY,  5,    32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_SET_MASK, 700,  32'd0,        32'hA5A5A5A5));
        push_req(build_req(gha_pkg::ACT_QUERY,    700,  32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_CREATE,   1023, 32'hFFFFFFFF, 32'hFFFFFFFF));
        push_req(build_req(gha_pkg::ACT_CREATE,   0,    32'd0,        32'd0));
        push_req(build_req(gha_pkg::ACT_CREATE,   341,  32'h55555555, 32'd1));
        push_req(build_req(gha_pkg::ACT_SET_MASK, 1,    32'h12345678, 32'd1));
        push_req(build_req(gha_pkg::ACT_QUERY,    1,    32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_QUERY,    2,    32'd2,        32'd0));
        push_req(build_req(gha_pkg::ACT_DESTROY,  0,    32'hFFFFFFFF, 32'h5A5A5A5A));
        push_req(build_req(gha_pkg::ACT_DESTROY,  0,    32'd2,        32'd0));
        push_req(build_req(gha_pkg::ACT_QUERY,    0,    32'd2,        32'd0));
        push_req(build_req(gha_pkg::ACT_CREATE,   682,  32'hAAAAAAAA, 32'h80000000));
        push_req(build_req(gha_pkg::ACT_SET_MASK, 1023, 32'd0,        32'hFFFFFFFE));
        push_req(build_req(gha_pkg::ACT_DESTROY,  1,    32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_DESTROY,  2,    32'd1,        32'd0));
        push_req(build_req(gha_pkg::ACT_QUERY,    1023, 32'd1,        32'd0));

        repeat (100) push_req(random_req(35, 30, 15));
        drain_responses();

        // fill the pool, then create against an empty free queue
        while (pool.free_count > 0) begin
            if ($urandom_range(0, 9) == 0)
                push_req(random_req(0, 0, 50));
            else
                push_req(build_req(gha_pkg::ACT_CREATE, $urandom_range(0, SLOTS - 1),
                                   $urandom, $urandom));
        end
        repeat (3) push_req(build_req(gha_pkg::ACT_CREATE, $urandom_range(0, SLOTS - 1),
                                      $urandom, $urandom));
        repeat (3) begin
            push_req(build_req(gha_pkg::ACT_DESTROY, live[$urandom_range(0, live.size() - 1)],
                               $urandom, $urandom));
            push_req(build_req(gha_pkg::ACT_CREATE, 0, 0, $urandom));
            push_req(build_req(gha_pkg::ACT_CREATE, 0, 0, $urandom));
        end

        for (int n = 0; n < 200; n++) begin
            if (n == 80)
                calm = 1'b1;
            push_req(random_req(20, 45, 15));
        end
        req_valid <= 1'b0;

        while (pool.due_rsps.size() > 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d responses checked, %0d creates on a full pool",
                 pool.requests, pool.checked, pool.full_hits);
        $display("%0d field mismatches", pool.mismatches);
        if (pool.mismatches == 0)
            $display("tb_generational_handle_allocator_unit OK");
        else
            $display("tb_generational_handle_allocator_unit NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/gha_pkg.sv
hdl/gha_ctrl.sv
hdl/gha_dpath.sv
hdl/generational_handle_allocator_unit.sv
sim/tb_generational_handle_allocator_unit.sv
